FILE: rtl/core/crlf_pkg.sv
`default_nettype none
package crlf_pkg;

	localparam int BUF_DEPTH = 32;
	localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int COUNT_W   = 6;

	localparam logic [1:0] ACT_BYTE = 2'd0;
	localparam logic [1:0] ACT_POLL = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	localparam logic [7:0] HDR_BYTE = 8'hFA;
	localparam logic [7:0] CR_BYTE  = 8'h0D;
	localparam logic [7:0] LF_BYTE  = 8'h0A;

	localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(BUF_DEPTH);

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

endpackage
`default_nettype wire

FILE: rtl/core/crlf_if.sv
`default_nettype none
interface crlf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic [4:0] read_index;

	modport source (output valid, action, rx_byte, read_index, input ready);
	modport sink   (input valid, action, rx_byte, read_index, output ready);
endinterface

interface crlf_out_if;
	logic       valid;
	logic       ready;
	logic       frame_done;
	logic [5:0] frame_length;
	logic [7:0] read_data;

	modport source (output valid, frame_done, frame_length, read_data, input ready);
	modport sink   (input valid, frame_done, frame_length, read_data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/crlf_store.sv
`default_nettype none
module crlf_store
	import crlf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wr_t               wr,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [7:0]        rd_data
);

	logic [7:0]           mem [BUF_DEPTH];
	logic [BUF_DEPTH-1:0] valid_q;
	logic [7:0]           rd_raw_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[rd_addr];
		end
	end

	// Entries never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : 8'h00;

endmodule
`default_nettype wire

FILE: rtl/core/crlf_ctrl.sv
`default_nettype none
module crlf_ctrl
	import crlf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [1:0]         action,
	input  wire logic [7:0]         rx_byte,
	output wr_t                     wr,
	output logic                    done,
	output logic      [COUNT_W-1:0] length
);

	logic [COUNT_W-1:0] count_q, count_d;
	logic               cr_q, cr_d;
	logic               complete_q, complete_d;

	always_comb begin
		count_d    = count_q;
		cr_d       = cr_q;
		complete_d = complete_q;
		wr.en      = 1'b0;
		wr.addr    = count_q[ADDR_W-1:0];
		wr.data    = rx_byte;
		done       = 1'b0;
		case (action)
			ACT_BYTE: begin
				if (complete_q) begin
					count_d = count_q;
				end else if (cr_q) begin
					if (rx_byte == LF_BYTE) begin
						complete_d = 1'b1;
					end else begin
						count_d = '0;
						cr_d    = 1'b0;
					end
				end else if (rx_byte == CR_BYTE) begin
					cr_d = 1'b1;
				end else if (count_q >= DEPTH_C) begin
					count_d = '0;
				end else begin
					wr.en = accept;
					// A stored count above zero means entry 0 already holds the header.
					if (count_q == '0 && rx_byte != HDR_BYTE) begin
						count_d = '0;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
			end
			ACT_POLL: begin
				if (complete_q) begin
					done       = 1'b1;
					count_d    = '0;
					cr_d       = 1'b0;
					complete_d = 1'b0;
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign length = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cr_q       <= 1'b0;
			complete_q <= 1'b0;
		end else if (accept) begin
			count_q    <= count_d;
			cr_q       <= cr_d;
			complete_q <= complete_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/crlf_frame_receiver.sv
// Collects received bytes into a 32-entry frame buffer. A frame must start with
// header byte 0xFA and ends with CR followed by LF, which are not stored. Each
// accepted word carries an action: store a byte, poll (reports and clears a
// complete frame), or read one stored byte. Exactly one result word follows
// each input word. One word is accepted every cycle while the result output is
// not stalled; the result appears in the cycle after acceptance, from an output
// register fed by the registered buffer memory read. The frame state updates
// within the accepting cycle, so consecutive words never wait on each other.
`default_nettype none
module crlf_frame_receiver
	import crlf_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	crlf_in_if.sink   item,
	crlf_out_if.source result
);

	logic               accept;
	wr_t                wr;
	logic               done;
	logic [COUNT_W-1:0] length;
	logic [COUNT_W-1:0] idx_ext;
	logic               rd_sel;
	logic [7:0]         rd_data;

	logic               valid_s1;
	logic               done_s1;
	logic [COUNT_W-1:0] length_s1;
	logic               rd_sel_s1;

	assign item.ready = !valid_s1 || result.ready;
	assign accept     = item.valid && item.ready;

	assign idx_ext = COUNT_W'(item.read_index);
	assign rd_sel  = (item.action == ACT_READ) && (idx_ext < DEPTH_C);

	crlf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (item.action),
		.rx_byte (item.rx_byte),
		.wr      (wr),
		.done    (done),
		.length  (length)
	);

	crlf_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (idx_ext[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			done_s1   <= done;
			length_s1 <= length;
			rd_sel_s1 <= rd_sel;
		end
	end

	assign result.valid        = valid_s1;
	assign result.frame_done   = done_s1;
	assign result.frame_length = length_s1;
	assign result.read_data    = rd_sel_s1 ? rd_data : 8'h00;

endmodule
`default_nettype wire
